// ===== sv/tlptw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_pkg
// Shared codes, types and constants of the page table walker.
// ----------------------------------------------------------------------------
package tlptw_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_READ      = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_MAP       = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOTABLE   = 4'd1,
    ST_NOTPRES   = 4'd2,
    ST_NOTUSER   = 4'd3,
    ST_BADFRAME  = 4'd4,
    ST_SAME      = 4'd5,
    ST_UPDATED   = 4'd6,
    ST_OVERWRITE = 4'd7,
    ST_REMAP     = 4'd8,
    ST_RANGE     = 4'd9
  } status_t;

  localparam logic [1:0] REG_PHYS_TOP    = 2'd0;
  localparam logic [1:0] REG_KERNEL_END  = 2'd1;
  localparam logic [1:0] REG_KERNEL_BASE = 2'd2;

  localparam logic [31:0] PHYS_TOP_RST    = 32'h0E00_0000;
  localparam logic [31:0] KERNEL_END_RST  = 32'h0010_0000;
  localparam logic [31:0] KERNEL_BASE_RST = 32'h8000_0000;

  localparam logic [31:0] PG_P       = 32'h0000_0001;
  localparam logic [31:0] PG_U       = 32'h0000_0004;
  localparam logic [31:0] PG_AD      = 32'h0000_0060;
  localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;

  // datapath -> controller
  typedef struct packed {
    logic    dir_range;   // directory word outside the store
    logic    dir_absent;  // P clear
    logic    dir_bad;     // table frame invalid (P not checked)
    logic    tbl_range;   // table word outside the store
    logic    wr_range;    // word command index outside the store
    logic    pte_write;   // map outcome needs a write-back
    status_t pte_status;  // outcome of translate/map on the entry
  } dp_status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,  // latch item, issue directory read or word access
    OP_DIR,      // directory data valid: clear bad entry or issue table read
    OP_PTE,      // table entry valid: compute outcome, write back
    OP_FINISH    // load result register from status
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t fin_status;
  } dp_cmd_t;

endpackage

// ===== sv/tlptw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_datapath
// Table store, item registers, entry checks and the result register.
// ----------------------------------------------------------------------------
module tlptw_datapath #(
  parameter int TABLE_WORDS = 16384
) (
  input  logic                  clk,
  input  tlptw_pkg::dp_cmd_t    cmd,
  output tlptw_pkg::dp_status_t sts,
  input  logic [1:0]            in_command,
  input  logic [19:0]           in_base,
  input  logic [31:0]           in_va,
  input  logic [19:0]           in_pframe,
  input  logic [11:0]           in_perm,
  input  logic [31:0]           in_wdata,
  input  logic [31:0]           phys_top,
  input  logic [31:0]           kernel_end,
  input  logic [31:0]           kernel_base,
  output logic [3:0]            res_status,
  output logic [19:0]           res_frame,
  output logic [31:0]           res_data
);
  localparam int AW = $clog2(TABLE_WORDS);

  logic [31:0] mem [TABLE_WORDS];
  logic [31:0] rdata;

  logic [1:0]  c_cmd;
  logic [31:0] c_va;
  logic [19:0] c_pframe;
  logic [11:0] c_perm;
  logic [AW-1:0] dir_addr;
  logic [AW-1:0] slot_addr;

  logic [39:0] in_dir_word;
  logic [39:0] tbl_word;
  logic [31:0] taddr, pa, want;
  logic [AW-1:0] acc_addr;
  logic        acc_we, acc_re;
  logic [31:0] acc_wdata;

  function automatic logic frame_ok(input logic [31:0] a, input logic [31:0] top,
                                    input logic [31:0] lo);
    frame_ok = (a != 32'd0) && (a < top) && (a >= lo);
  endfunction

  assign in_dir_word = {10'd0, in_base, 10'd0} + {30'd0, in_va[31:22]};
  assign taddr       = rdata & tlptw_pkg::FRAME_MASK;
  assign tbl_word    = {10'd0, taddr[31:12], 10'd0} + {30'd0, c_va[21:12]};
  assign pa          = {c_pframe, 12'd0};
  assign want        = pa | {20'd0, c_perm} | tlptw_pkg::PG_P;

  always_comb begin
    sts.dir_range  = 1'b0;
    sts.wr_range   = ({8'd0, in_va} >= 40'(TABLE_WORDS));
    sts.dir_absent = (rdata & tlptw_pkg::PG_P) == 32'd0;
    sts.dir_bad    = !frame_ok(taddr, phys_top, kernel_end);
    sts.tbl_range  = tbl_word >= 40'(TABLE_WORDS);
    sts.pte_write  = 1'b0;
    sts.pte_status = tlptw_pkg::ST_OK;
    if (in_dir_word >= 40'(TABLE_WORDS)) sts.dir_range = 1'b1;
    if (c_cmd == tlptw_pkg::CMD_TRANSLATE) begin
      priority if ((rdata & tlptw_pkg::PG_P) == 32'd0) sts.pte_status = tlptw_pkg::ST_NOTPRES;
      else if ((rdata & tlptw_pkg::PG_U) == 32'd0) sts.pte_status = tlptw_pkg::ST_NOTUSER;
      else if (!frame_ok(taddr, phys_top, kernel_end))
        sts.pte_status = tlptw_pkg::ST_BADFRAME;
      else sts.pte_status = tlptw_pkg::ST_OK;
    end else begin
      priority if ((rdata & tlptw_pkg::PG_P) == 32'd0) begin
        sts.pte_write = 1'b1;
      end else if ((rdata & ~tlptw_pkg::PG_AD) == want) begin
        sts.pte_status = tlptw_pkg::ST_SAME;
      end else if (taddr == pa) begin
        sts.pte_status = tlptw_pkg::ST_UPDATED;
        sts.pte_write  = 1'b1;
      end else if ((c_va & tlptw_pkg::FRAME_MASK) >= kernel_base) begin
        sts.pte_status = tlptw_pkg::ST_OVERWRITE;
        sts.pte_write  = 1'b1;
      end else begin
        sts.pte_status = tlptw_pkg::ST_REMAP;
      end
    end
  end

  // single store port per cycle
  always_comb begin
    acc_addr  = dir_addr;
    acc_we    = 1'b0;
    acc_re    = 1'b0;
    acc_wdata = in_wdata;
    unique case (cmd.op)
      tlptw_pkg::OP_CAPTURE: begin
        if (in_command == tlptw_pkg::CMD_WRITE || in_command == tlptw_pkg::CMD_READ) begin
          acc_addr = in_va[AW-1:0];
          acc_we   = !sts.wr_range && (in_command == tlptw_pkg::CMD_WRITE);
          acc_re   = !sts.wr_range && (in_command == tlptw_pkg::CMD_READ);
        end else begin
          acc_addr = in_dir_word[AW-1:0];
          acc_re   = !sts.dir_range;
        end
      end
      tlptw_pkg::OP_DIR: begin
        if (sts.dir_bad && !sts.dir_absent) begin
          acc_addr  = dir_addr;
          acc_we    = 1'b1;
          acc_wdata = 32'd0;
        end else begin
          acc_addr = tbl_word[AW-1:0];
          acc_re   = !sts.dir_absent && !sts.tbl_range;
        end
      end
      tlptw_pkg::OP_PTE: begin
        acc_addr  = slot_addr;
        acc_we    = (c_cmd == tlptw_pkg::CMD_MAP) && sts.pte_write;
        acc_wdata = ((rdata & tlptw_pkg::PG_P) == 32'd0) ? want
                  : (want | (rdata & tlptw_pkg::PG_AD));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_we) mem[acc_addr] <= acc_wdata;
    if (acc_re) rdata <= mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tlptw_pkg::OP_CAPTURE: begin
        c_cmd    <= in_command;
        c_va     <= in_va;
        c_pframe <= in_pframe;
        c_perm   <= in_perm;
        dir_addr <= in_dir_word[AW-1:0];
      end
      tlptw_pkg::OP_DIR: begin
        slot_addr <= tbl_word[AW-1:0];
        // walk ends at the directory: no usable table, or table word off the store
        if (sts.dir_absent || sts.dir_bad) begin
          res_status <= tlptw_pkg::ST_NOTABLE;
          res_frame  <= 20'd0;
          res_data   <= 32'd0;
        end else if (sts.tbl_range) begin
          res_status <= tlptw_pkg::ST_RANGE;
          res_frame  <= 20'd0;
          res_data   <= 32'd0;
        end
      end
      tlptw_pkg::OP_PTE: begin
        res_status <= sts.pte_status;
        res_frame  <= (c_cmd == tlptw_pkg::CMD_TRANSLATE &&
                       sts.pte_status == tlptw_pkg::ST_OK) ? rdata[31:12] : 20'd0;
        res_data   <= (c_cmd == tlptw_pkg::CMD_MAP)
                    ? ((sts.pte_write) ? acc_wdata : rdata) : 32'd0;
      end
      tlptw_pkg::OP_FINISH: begin
        res_status <= cmd.fin_status;
        res_frame  <= 20'd0;
        res_data   <= (cmd.fin_status == tlptw_pkg::ST_OK &&
                       c_cmd == tlptw_pkg::CMD_READ) ? rdata : 32'd0;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tlptw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_ctrl
// Sequencer for the walk and the output handshake.
// ----------------------------------------------------------------------------
module tlptw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  tlptw_pkg::dp_status_t sts,
  output tlptw_pkg::dp_cmd_t    cmd
);
  typedef enum logic [2:0] {S_IDLE, S_WORD, S_DIR, S_PTE, S_OUT} state_t;
  state_t state;
  logic   c_range;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    cmd.op         = tlptw_pkg::OP_NONE;
    cmd.fin_status = tlptw_pkg::ST_OK;
    unique case (state)
      S_IDLE, S_OUT: if (in_valid && in_ready) cmd.op = tlptw_pkg::OP_CAPTURE;
      S_WORD: begin
        cmd.op = tlptw_pkg::OP_FINISH;
        cmd.fin_status = c_range ? tlptw_pkg::ST_RANGE : tlptw_pkg::ST_OK;
      end
      S_DIR: begin
        cmd.op = tlptw_pkg::OP_DIR;
      end
      S_PTE: cmd.op = tlptw_pkg::OP_PTE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      c_range   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE, S_OUT: begin
          if (in_valid && in_ready) begin
            out_valid <= 1'b0;
            if ((in_command == tlptw_pkg::CMD_WRITE) ||
                (in_command == tlptw_pkg::CMD_READ)) begin
              c_range <= sts.wr_range;
              state   <= S_WORD;
            end else begin
              c_range <= sts.dir_range;
              state   <= sts.dir_range ? S_WORD : S_DIR;
            end
          end else if (state == S_OUT && out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_WORD: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_DIR: begin
          if (sts.dir_absent || sts.dir_bad) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else if (sts.tbl_range) begin
            state <= S_OUT;
            out_valid <= 1'b1;
          end else state <= S_PTE;
        end
        S_PTE: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/two_level_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_walker
// Page table walker over an internal word store: word access, translate, map.
// ----------------------------------------------------------------------------
// Word commands pass through S_WORD and walks that stop at the directory through
// S_DIR (S_WORD if the directory word is off the store); a full walk passes
// through S_DIR then S_PTE. tvalid rises on entry to S_OUT. One item in flight;
// the next item is accepted at the edge that takes the result beat.
// The store has one port: directory read, table read, write-back in turn.
// Reset (rst, synchronous) clears control and the configuration registers; store undefined.
// ----------------------------------------------------------------------------
module two_level_page_table_walker #(
  parameter int TABLE_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] command, [21:2] table_base_frame, [53:22] virt_addr,
  // [73:54] phys_frame, [85:74] perm_bits, [117:86] write_data
  input  logic [119:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] status, [23:4] result_frame, [55:24] read_data
  output logic [55:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] phys_top, kernel_end, kernel_base;
  tlptw_pkg::dp_cmd_t    cmd;
  tlptw_pkg::dp_status_t sts;
  logic [3:0]  res_status;
  logic [19:0] res_frame;
  logic [31:0] res_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_top    <= tlptw_pkg::PHYS_TOP_RST;
      kernel_end  <= tlptw_pkg::KERNEL_END_RST;
      kernel_base <= tlptw_pkg::KERNEL_BASE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        tlptw_pkg::REG_PHYS_TOP:    phys_top    <= pwdata;
        tlptw_pkg::REG_KERNEL_END:  kernel_end  <= pwdata;
        tlptw_pkg::REG_KERNEL_BASE: kernel_base <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tlptw_pkg::REG_PHYS_TOP:    prdata = phys_top;
      tlptw_pkg::REG_KERNEL_END:  prdata = kernel_end;
      tlptw_pkg::REG_KERNEL_BASE: prdata = kernel_base;
      default:                    prdata = 32'd0;
    endcase
  end

  tlptw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_command (s_tdata[1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath loads the result register at the last step of each item:
  // word finish, directory stop or table entry.
  tlptw_datapath #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_command  (s_tdata[1:0]),
    .in_base     (s_tdata[21:2]),
    .in_va       (s_tdata[53:22]),
    .in_pframe   (s_tdata[73:54]),
    .in_perm     (s_tdata[85:74]),
    .in_wdata    (s_tdata[117:86]),
    .phys_top    (phys_top),
    .kernel_end  (kernel_end),
    .kernel_base (kernel_base),
    .res_status  (res_status),
    .res_frame   (res_frame),
    .res_data    (res_data)
  );

  assign m_tdata = {res_data, res_frame, res_status};

endmodule

// ===== sv/tlptw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlptw_checker
// Port-level checks of the page table walker.
// ----------------------------------------------------------------------------
module tlptw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= tlptw_pkg::ST_RANGE)
    else $error("status code out of range");
  a_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] != tlptw_pkg::ST_OK |-> m_tdata[23:4] == 20'd0)
    else $error("frame nonzero on failed item");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result shown before item finished");
endmodule

bind two_level_page_table_walker tlptw_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
